// ----- rtl/tet_pkg.sv -----
// Shared types, widths and codes for the tone effect ticker.
`default_nettype none

package tet_pkg;

  localparam int FREQ_W     = 16;
  localparam int LEN_W      = 16;
  localparam int LOOPS_W    = 8;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // input action codes
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  // loop modes
  localparam logic [1:0] LOOP_NONE    = 2'd0;
  localparam logic [1:0] LOOP_FOREVER = 2'd1;
  localparam logic [1:0] LOOP_COUNTED = 2'd2;

  // effect flag bit positions
  localparam int FX_ALT_BIT  = 0;
  localparam int FX_MONO_BIT = 1;
  localparam int FX_GATE_BIT = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_COUNT    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_FLAGS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_TRIGGER = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_HOLD    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_TRIGGER  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_HOLD     = 4'd7;

  typedef struct packed {
    logic              action;
    logic [FREQ_W-1:0] start_frequency;
    logic [LEN_W-1:0]  start_length;
    logic              playback_off;
  } in_item_t;

  typedef struct packed {
    logic              sound_off;
    logic [FREQ_W-1:0] tone_frequency;
    logic              active;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic [1:0]                loop_mode;
    logic [LOOPS_W-1:0]        loop_count;
    logic [2:0]                effect_flags;
    logic signed [FREQ_W-1:0]  sweep_step;
    logic [CNT_W-1:0]          sweep_trigger;
    logic [CNT_W-1:0]          sweep_hold;
    logic [CNT_W-1:0]          gate_trigger;
    logic [CNT_W-1:0]          gate_hold;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/tet_if.sv -----
// Handshake channel interfaces: command items, result items, config writes.
`default_nettype none

interface tet_cmd_if;
  logic              valid;
  logic              ready;
  tet_pkg::in_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

interface tet_res_if;
  logic               valid;
  logic               ready;
  tet_pkg::out_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

interface tet_cfg_if;
  logic                valid;
  logic                ready;
  tet_pkg::cfg_write_t wr;
  modport source(output valid, output wr, input ready);
  modport sink(input valid, input wr, output ready);
endinterface

`default_nettype wire

// ----- rtl/tet_regs.sv -----
// Configuration register file with index decode.
`default_nettype none

module tet_regs (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire tet_pkg::cfg_write_t wr,
  output tet_pkg::cfg_t            cfg
);

  tet_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en) begin
      unique case (wr.index)
        tet_pkg::REG_LOOP_MODE:     regs.loop_mode     <= wr.data[1:0];
        tet_pkg::REG_LOOP_COUNT:    regs.loop_count    <= wr.data[tet_pkg::LOOPS_W-1:0];
        tet_pkg::REG_EFFECT_FLAGS:  regs.effect_flags  <= wr.data[2:0];
        tet_pkg::REG_SWEEP_STEP:    regs.sweep_step    <= wr.data;
        tet_pkg::REG_SWEEP_TRIGGER: regs.sweep_trigger <= wr.data;
        tet_pkg::REG_SWEEP_HOLD:    regs.sweep_hold    <= wr.data;
        tet_pkg::REG_GATE_TRIGGER:  regs.gate_trigger  <= wr.data;
        tet_pkg::REG_GATE_HOLD:     regs.gate_hold     <= wr.data;
        default: ; // unmapped index: dropped
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ----- rtl/tet_core.sv -----
// Sound state registers and the combinational frame step logic.
`default_nettype none

module tet_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step_en,
  input  wire tet_pkg::in_item_t  item,
  input  wire tet_pkg::cfg_t      cfg,
  output tet_pkg::out_item_t      result
);

  typedef struct packed {
    logic [tet_pkg::CNT_W-1:0]  counter;
    logic [tet_pkg::FREQ_W-1:0] freq;
  } sweep_t;

  function automatic sweep_t sweep_fn(
    input logic [tet_pkg::CNT_W-1:0]  cnt,
    input logic [tet_pkg::FREQ_W-1:0] freq,
    input logic [tet_pkg::FREQ_W-1:0] step,
    input logic [tet_pkg::CNT_W-1:0]  trig,
    input logic [tet_pkg::CNT_W-1:0]  hold,
    input logic                       sub
  );
    sweep_t r;
    r.counter = cnt + 1'b1;
    r.freq    = freq;
    if (r.counter > trig) begin
      r.freq = sub ? (freq - step) : (freq + step);
      if (r.counter > hold) r.counter = '0;
    end
    return r;
  endfunction

  logic [tet_pkg::LEN_W-1:0]   frames_left, frames_left_next;
  logic [tet_pkg::LEN_W-1:0]   reload_length, reload_length_next;
  logic [1:0]                  loop_state, loop_state_next;
  logic [tet_pkg::LOOPS_W-1:0] loops_left, loops_left_next;
  logic [tet_pkg::FREQ_W-1:0]  current_frequency, current_frequency_next;
  logic [tet_pkg::CNT_W-1:0]   sweep_counter, sweep_counter_next;
  logic [tet_pkg::CNT_W-1:0]   gate_counter, gate_counter_next;

  logic [tet_pkg::LEN_W-1:0]   fl_dec;
  sweep_t                      sw_alt, sw_mono;
  logic [tet_pkg::CNT_W-1:0]   gate_inc;
  logic                        off;

  always_comb begin
    fl_dec = frames_left - 1'b1;

    // alternating sweep then monotone sweep, sharing one counter
    sw_alt = '{counter: sweep_counter, freq: current_frequency};
    if (cfg.effect_flags[tet_pkg::FX_ALT_BIT])
      sw_alt = sweep_fn(sweep_counter, current_frequency, cfg.sweep_step,
                        cfg.sweep_trigger, cfg.sweep_hold, fl_dec[0]);
    sw_mono = sw_alt;
    if (cfg.effect_flags[tet_pkg::FX_MONO_BIT])
      sw_mono = sweep_fn(sw_alt.counter, sw_alt.freq, cfg.sweep_step,
                         cfg.sweep_trigger, cfg.sweep_hold, 1'b0);
    gate_inc = gate_counter + 1'b1;

    frames_left_next       = frames_left;
    reload_length_next     = reload_length;
    loop_state_next        = loop_state;
    loops_left_next        = loops_left;
    current_frequency_next = current_frequency;
    sweep_counter_next     = sweep_counter;
    gate_counter_next      = gate_counter;
    off                    = 1'b0;

    if (item.action == tet_pkg::ACT_START) begin
      frames_left_next       = item.start_length;
      reload_length_next     = item.start_length;
      current_frequency_next = item.start_frequency;
      loop_state_next        = cfg.loop_mode;
      loops_left_next        = cfg.loop_count;
      sweep_counter_next     = '0;
      gate_counter_next      = '0;
    end else if (frames_left == '0) begin
      off = 1'b1; // idle tick
    end else begin
      frames_left_next = fl_dec;
      if (fl_dec == '0) begin
        if (loop_state != tet_pkg::LOOP_NONE) begin
          frames_left_next = reload_length;
          if (loop_state == tet_pkg::LOOP_FOREVER) begin
            // keep repeating
          end else if (loop_state == tet_pkg::LOOP_COUNTED && loops_left != '0) begin
            loops_left_next = loops_left - 1'b1;
          end else begin
            // budget spent or undefined mode
            loop_state_next  = tet_pkg::LOOP_NONE;
            frames_left_next = '0;
            off              = 1'b1;
          end
        end
      end else if (item.playback_off) begin
        frames_left_next = '0;
        off              = 1'b1;
      end else begin
        sweep_counter_next     = sw_mono.counter;
        current_frequency_next = sw_mono.freq;
        if (cfg.effect_flags[tet_pkg::FX_GATE_BIT]) begin
          gate_counter_next = gate_inc;
          if (gate_inc > cfg.gate_trigger) begin
            if (gate_inc > cfg.gate_hold) gate_counter_next = '0;
            off = 1'b1;
          end
        end
      end
    end

    result.sound_off      = off;
    result.tone_frequency = current_frequency_next;
    result.active         = (frames_left_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_left       <= '0;
      reload_length     <= '0;
      loop_state        <= tet_pkg::LOOP_NONE;
      loops_left        <= '0;
      current_frequency <= '0;
      sweep_counter     <= '0;
      gate_counter      <= '0;
    end else if (step_en) begin
      frames_left       <= frames_left_next;
      reload_length     <= reload_length_next;
      loop_state        <= loop_state_next;
      loops_left        <= loops_left_next;
      current_frequency <= current_frequency_next;
      sweep_counter     <= sweep_counter_next;
      gate_counter      <= gate_counter_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tone_effect_ticker.sv -----
// Top level: tone effect frame sequencer with config port and result skid buffer.
// A result is valid the cycle after its command transfer (output stage empty).
// Throughput: one command per cycle while skid is free; single registered state pass.
// A stalled result buffers one more transfer in the skid stage before cmd.ready drops.
// Reset (rst, synchronous, active high) zeroes all config registers and sound state
// and empties both result stages; no clearing pass is needed.
`default_nettype none

module tone_effect_ticker (
  input  wire logic clk,
  input  wire logic rst,
  tet_cmd_if.sink   cmd,
  tet_res_if.source res,
  tet_cfg_if.sink   cfg
);

  tet_pkg::cfg_t      cfg_regs;
  tet_pkg::out_item_t step_result;
  logic               cmd_fire;

  // output stage plus one skid entry
  logic               out_valid;
  tet_pkg::out_item_t out_item;
  logic               skid_valid;
  tet_pkg::out_item_t skid_item;

  // Config writes are always taken; software writes only while the block is idle.
  assign cfg.ready = 1'b1;

  tet_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg.valid),
    .wr    (cfg.wr),
    .cfg   (cfg_regs)
  );

  // Commands are taken whenever the skid entry is free, so one transfer still
  // lands while the downstream side holds off.
  assign cmd.ready = !skid_valid;
  assign cmd_fire  = cmd.valid && cmd.ready;

  // State advances on the transfer edge; result is formed in the same pass.
  tet_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (cmd_fire),
    .item    (cmd.item),
    .cfg     (cfg_regs),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !res.ready) begin
      // output stalled: park a new result in the skid entry
      if (cmd_fire) begin
        skid_valid <= 1'b1;
        skid_item  <= step_result;
      end
    end else if (skid_valid) begin
      // output drained: refill from skid (no command can transfer this cycle)
      out_valid  <= 1'b1;
      out_item   <= skid_item;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= cmd_fire;
      out_item  <= step_result;
    end
  end

  assign res.valid = out_valid;
  assign res.item  = out_item;

endmodule

`default_nettype wire

// ----- rtl/tet_checker.sv -----
// Port-level assertions for the tone effect ticker, bound to the top level.
`default_nettype none

module tet_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cmd_valid,
  input wire logic               cmd_ready,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire tet_pkg::out_item_t res_item,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready
);

  // reset empties the result path
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // a transfer into an empty output stage shows up the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && !res_valid) |=> res_valid)
    else $error("result missing one cycle after transfer");

  // back pressure on commands only when a result is pending
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> (res_valid && $past(res_valid && !res_ready)))
    else $error("command stalled without a pending result");

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_item)))
    else $error("stalled result changed");

  // config port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind tone_effect_ticker tet_checker u_tet_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_item  (res.item),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready)
);

`default_nettype wire

// ----- test/tone_effect_checker.sv -----
// Checker for the tone effect ticker: tracks config writes, predicts each frame result, compares.
module tone_effect_checker (
  input  logic      clk,
  input  logic      rst,
  tet_cmd_if        cmd,
  tet_res_if        res,
  tet_cfg_if        cfg,
  output int        outstanding,
  output int        fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  tet_pkg::cfg_t                regs;
  logic [tet_pkg::LEN_W-1:0]    frames_left;
  logic [tet_pkg::LEN_W-1:0]    reload_len;
  logic [1:0]                   loop_st;
  logic [tet_pkg::LOOPS_W-1:0]  loops_left;
  logic [tet_pkg::FREQ_W-1:0]   freq;
  logic [tet_pkg::CNT_W-1:0]    sweep_cnt;
  logic [tet_pkg::CNT_W-1:0]    gate_cnt;
  tet_pkg::out_item_t           expected_tones[$];

  // Field widths truncate the write data; unknown indexes are dropped.
  function automatic void apply_write(logic [tet_pkg::CFG_IDX_W-1:0]  idx,
                                      logic [tet_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      tet_pkg::REG_LOOP_MODE:     regs.loop_mode     = data[1:0];
      tet_pkg::REG_LOOP_COUNT:    regs.loop_count    = data[tet_pkg::LOOPS_W-1:0];
      tet_pkg::REG_EFFECT_FLAGS:  regs.effect_flags  = data[2:0];
      tet_pkg::REG_SWEEP_STEP:    regs.sweep_step    = data;
      tet_pkg::REG_SWEEP_TRIGGER: regs.sweep_trigger = data;
      tet_pkg::REG_SWEEP_HOLD:    regs.sweep_hold    = data;
      tet_pkg::REG_GATE_TRIGGER:  regs.gate_trigger  = data;
      tet_pkg::REG_GATE_HOLD:     regs.gate_hold     = data;
      default: ;
    endcase
  endfunction

  // Shared sweep counter; alternate mode subtracts on odd remaining frames.
  function automatic void sweep_tick(bit alternate);
    sweep_cnt = sweep_cnt + 1'b1;
    if (sweep_cnt > regs.sweep_trigger) begin
      if (alternate && frames_left[0])
        freq = freq - regs.sweep_step;
      else
        freq = freq + regs.sweep_step;
      if (sweep_cnt > regs.sweep_hold)
        sweep_cnt = '0;
    end
  endfunction

  function automatic tet_pkg::out_item_t tone_step(tet_pkg::in_item_t it);
    tet_pkg::out_item_t r;
    logic               off;
    off = 1'b0;
    if (it.action == tet_pkg::ACT_START) begin
      frames_left = it.start_length;
      reload_len  = it.start_length;
      freq        = it.start_frequency;
      loop_st     = regs.loop_mode;
      loops_left  = regs.loop_count;
      sweep_cnt   = '0;
      gate_cnt    = '0;
    end else if (frames_left == 0) begin
      off = 1'b1;
    end else begin
      frames_left = frames_left - 1'b1;
      if (frames_left == 0) begin
        // final frame: no effects, no stop request
        if (loop_st != tet_pkg::LOOP_NONE) begin
          frames_left = reload_len;
          if (loop_st == tet_pkg::LOOP_COUNTED && loops_left != 0) begin
            loops_left = loops_left - 1'b1;
          end else if (loop_st != tet_pkg::LOOP_FOREVER) begin
            loop_st     = tet_pkg::LOOP_NONE;
            frames_left = '0;
            off         = 1'b1;
          end
        end
      end else if (it.playback_off) begin
        frames_left = '0;
        off         = 1'b1;
      end else begin
        if (regs.effect_flags[tet_pkg::FX_ALT_BIT])
          sweep_tick(1'b1);
        if (regs.effect_flags[tet_pkg::FX_MONO_BIT])
          sweep_tick(1'b0);
        if (regs.effect_flags[tet_pkg::FX_GATE_BIT]) begin
          gate_cnt = gate_cnt + 1'b1;
          if (gate_cnt > regs.gate_trigger) begin
            if (gate_cnt > regs.gate_hold)
              gate_cnt = '0;
            off = 1'b1;
          end
        end
      end
    end
    r.sound_off      = off;
    r.tone_frequency = freq;
    r.active         = (frames_left != 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    tet_pkg::out_item_t want;
    if (rst) begin
      regs        = '0;
      frames_left = '0;
      reload_len  = '0;
      loop_st     = tet_pkg::LOOP_NONE;
      loops_left  = '0;
      freq        = '0;
      sweep_cnt   = '0;
      gate_cnt    = '0;
      fail_count  = 0;
      expected_tones.delete();
    end else begin
      if (cfg.valid && cfg.ready)
        apply_write(cfg.wr.index, cfg.wr.data);
      if (res.valid && res.ready) begin
        if (expected_tones.size() == 0) begin
          $display("%0t: result with none pending, expected nothing, actual %0h",
                   $time, res.item);
          fail_count++;
        end else begin
          want = expected_tones.pop_front();
          check_field("sound_off", 16'(want.sound_off), 16'(res.item.sound_off));
          check_field("tone_frequency", want.tone_frequency, res.item.tone_frequency);
          check_field("active", 16'(want.active), 16'(res.item.active));
        end
      end
      // a command result cannot leave in the cycle it is taken, so push after pop
      if (cmd.valid && cmd.ready)
        expected_tones.push_back(tone_step(cmd.item));
    end
    outstanding = expected_tones.size();
  end

endmodule

// ----- test/tb_tone_effect_ticker.sv -----
// Testbench top: drives commands and config writes, flow-controls results, reports verdict.
module tb_tone_effect_ticker;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [tet_pkg::FREQ_W-1:0]     freq_t;
  typedef logic [tet_pkg::LEN_W-1:0]      len_t;
  typedef logic [tet_pkg::LOOPS_W-1:0]    loops_t;
  typedef logic [tet_pkg::CNT_W-1:0]      cnt_t;
  typedef logic [tet_pkg::CFG_IDX_W-1:0]  idx_t;
  typedef logic [tet_pkg::CFG_DATA_W-1:0] data_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 56;
  localparam int LONG_HOLD   = 80;    // cycles of result back-pressure, once
  localparam int HOLD_AT     = 150;   // transfers sent before that hold starts
  localparam int SETTLE      = 4;     // output stage plus skid, with margin

  localparam logic [2:0] FX_ALT  = 3'(1 << tet_pkg::FX_ALT_BIT);
  localparam logic [2:0] FX_MONO = 3'(1 << tet_pkg::FX_MONO_BIT);
  localparam logic [2:0] FX_GATE = 3'(1 << tet_pkg::FX_GATE_BIT);

  // unused loop mode code; behaves as a spent counted loop
  localparam logic [1:0] LOOP_RESERVED = 2'd3;

  logic clk;
  logic rst;
  int   cycles;
  int   sent;
  int   send_idle_pct;
  int   res_idle_pct;
  bit   quiet;          // last phase: no idling on either side
  int   outstanding;
  int   fail_count;

  tet_cmd_if cmd_ch();
  tet_res_if res_ch();
  tet_cfg_if cfg_ch();

  tone_effect_ticker dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  tone_effect_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .res         (res_ch),
    .cfg         (cfg_ch),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop if the run hangs on a handshake or never drains.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random ready bursts, plus one long hold so the skid fills
  // and cmd.ready has to drop while commands keep coming.
  initial begin
    int  hold_left;
    bit  long_done;
    hold_left = 0;
    long_done = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0)
        hold_left--;
      else if (!long_done && sent >= HOLD_AT) begin
        hold_left = LONG_HOLD;
        long_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < res_idle_pct)
        hold_left = $urandom_range(1, 5);
      res_ch.ready <= (hold_left == 0);
    end
  end

  // --- command helpers ---

  function automatic tet_pkg::in_item_t tick_item(bit stop);
    tet_pkg::in_item_t it;
    it.action          = tet_pkg::ACT_TICK;
    it.start_frequency = 16'($urandom);   // ignored on a tick
    it.start_length    = 16'($urandom);
    it.playback_off    = stop;
    return it;
  endfunction

  function automatic tet_pkg::in_item_t start_item(freq_t f, len_t len);
    tet_pkg::in_item_t it;
    it.action          = tet_pkg::ACT_START;
    it.start_frequency = f;
    it.start_length    = len;
    it.playback_off    = 1'($urandom_range(0, 1));   // ignored on a start
    return it;
  endfunction

  // one transfer; optional idle burst in front of it
  task automatic send_item(tet_pkg::in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 5);
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.item  <= it;
    do @(posedge clk); while (!cmd_ch.ready);
    sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(tick_item(1'b0));
  endtask

  // drop valid, let every expected result come back, then let the pipe settle
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // --- config helpers ---

  task automatic write_reg(idx_t idx, data_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.wr    <= '{index: idx, data: data};
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // narrow registers get junk in the unused upper data bits
  function automatic data_t pad_junk(data_t v, int w);
    data_t mask;
    mask = (data_t'(1) << w) - 1'b1;
    return (data_t'($urandom) & ~mask) | (v & mask);
  endfunction

  task automatic configure(tet_pkg::cfg_t c);
    // occasionally hit an unmapped index; it must change nothing
    if ($urandom_range(0, 99) < 30)
      write_reg(idx_t'(tet_pkg::REG_GATE_HOLD + 1 + $urandom_range(0, 7)), data_t'($urandom));
    write_reg(tet_pkg::REG_LOOP_MODE, pad_junk(data_t'(c.loop_mode), 2));
    write_reg(tet_pkg::REG_LOOP_COUNT, pad_junk(data_t'(c.loop_count), tet_pkg::LOOPS_W));
    write_reg(tet_pkg::REG_EFFECT_FLAGS, pad_junk(data_t'(c.effect_flags), 3));
    write_reg(tet_pkg::REG_SWEEP_STEP, c.sweep_step);
    write_reg(tet_pkg::REG_SWEEP_TRIGGER, c.sweep_trigger);
    write_reg(tet_pkg::REG_SWEEP_HOLD, c.sweep_hold);
    write_reg(tet_pkg::REG_GATE_TRIGGER, c.gate_trigger);
    write_reg(tet_pkg::REG_GATE_HOLD, c.gate_hold);
    cfg_ch.valid <= 1'b0;
  endtask

  // thresholds: mostly small so effects fire and counters restart often
  function automatic cnt_t pick_threshold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)      return '1;
    else if (r < 25) return '0;
    else if (r < 35) return cnt_t'($urandom);
    else             return cnt_t'($urandom_range(1, 6));
  endfunction

  function automatic tet_pkg::cfg_t rand_cfg();
    tet_pkg::cfg_t c;
    c.loop_mode = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       c.loop_count = '0;
      1:       c.loop_count = '1;
      default: c.loop_count = loops_t'($urandom_range(1, 4));
    endcase
    c.effect_flags = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 1))
      c.sweep_step = freq_t'($urandom);
    else
      c.sweep_step = freq_t'($urandom_range(0, 20) - 10);
    c.sweep_trigger = pick_threshold();
    c.sweep_hold    = pick_threshold();
    c.gate_trigger  = pick_threshold();
    c.gate_hold     = pick_threshold();
    return c;
  endfunction

  // short lengths keep loops and wraps reachable; a few zero or huge
  function automatic len_t pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)      return '0;
    else if (r < 5) return '1;
    else if (r < 7) return len_t'($urandom);
    else            return len_t'($urandom_range(1, 10));
  endfunction

  // --- stimulus ---

  initial begin
    int r;
    rst           = 1'b1;
    sent          = 0;
    quiet         = 1'b0;
    send_idle_pct = 25;
    res_idle_pct  = 25;
    cmd_ch.valid  = 1'b0;
    cmd_ch.item   = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.wr     = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset config: idle ticks are muted and change nothing,
    // zero length is idle at once, the last frame of an unlooped sound plays
    // unmuted and the next tick is muted, a stop request ends the sound.
    send_item(tick_item(1'b1));
    send_item(start_item('1, '0));
    send_item(tick_item(1'b0));
    send_item(start_item('0, 16'd2));
    send_ticks(3);
    send_item(start_item(16'h1234, 16'd3));
    send_item(tick_item(1'b1));
    send_item(tick_item(1'b0));
    drain();

    // Loop forever with every effect on and the most negative step;
    // zero thresholds so sweeps and gate act on every frame but the last of each pass.
    configure('{loop_mode: tet_pkg::LOOP_FOREVER, loop_count: '0,
                effect_flags: FX_ALT | FX_MONO | FX_GATE, sweep_step: 16'h8000,
                sweep_trigger: '0, sweep_hold: '0, gate_trigger: '0, gate_hold: '0});
    send_item(start_item(16'h00FF, 16'd2));
    send_ticks(4);
    drain();

    // Counted loop with one repeat, alternating sweep at max positive step.
    configure('{loop_mode: tet_pkg::LOOP_COUNTED, loop_count: 8'd1,
                effect_flags: FX_ALT, sweep_step: 16'h7FFF,
                sweep_trigger: 16'd1, sweep_hold: 16'd2,
                gate_trigger: 16'd1, gate_hold: 16'd3});
    send_item(start_item('1, 16'd2));
    send_ticks(5);
    drain();

    // Undefined loop mode three acts as an exhausted counted loop;
    // thresholds at max never fire.
    configure('{loop_mode: LOOP_RESERVED, loop_count: '1,
                effect_flags: FX_MONO | FX_GATE, sweep_step: 16'hFFFF,
                sweep_trigger: '1, sweep_hold: '1, gate_trigger: '1, gate_hold: '1});
    send_item(start_item('0, 16'd2));
    send_ticks(2);
    send_item(start_item('1, '1));
    send_item(tick_item(1'b0));
    drain();

    // Random phases: new config each time, then mostly start-then-tick runs
    // with occasional stop requests and restarts mid-sound.
    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == PHASES - 1);
      case ($urandom_range(0, 2))
        0:       send_idle_pct = 0;
        1:       send_idle_pct = 20;
        default: send_idle_pct = 40;
      endcase
      res_idle_pct = 10 * $urandom_range(0, 4);
      configure(rand_cfg());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 14)
          send_item(start_item(freq_t'($urandom), pick_length()));
        else
          send_item(tick_item($urandom_range(0, 99) < 5));
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tet_pkg.sv
rtl/tet_if.sv
rtl/tet_regs.sv
rtl/tet_core.sv
rtl/tone_effect_ticker.sv
rtl/tet_checker.sv
test/tone_effect_checker.sv
test/tb_tone_effect_ticker.sv
